// ----- hw/rtl/kct_pkg.sv -----
package kct_pkg;

	// Default table capacity
	localparam int CAPACITY_DEF = 8;

	localparam int KEY_W   = 16;
	localparam int PAY_W   = 32;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 4;

	// Operation codes of a request
	typedef enum logic [KIND_W-1:0] {
		OP_ADD    = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_DUP     = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// One table entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

endpackage

// ----- hw/rtl/kct_if.sv -----
// Request channel
interface kct_req_if;
	import kct_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	logic [PAY_W-1:0]  entry_payload;

	modport source(output valid, output kind, output key, output entry_payload, input ready);
	modport sink(input valid, input kind, input key, input entry_payload, output ready);
endinterface

// Result channel
interface kct_rsp_if;
	import kct_pkg::*;
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [PAY_W-1:0]   found_payload;
	logic [COUNT_W-1:0] entry_count;

	modport source(output valid, output status, output found_payload, output entry_count,
		input ready);
	modport sink(input valid, input status, input found_payload, input entry_count,
		output ready);
endinterface

// ----- hw/rtl/kct_store.sv -----
// Entry storage: one write port, one read port with registered data
module kct_store #(
	parameter int CAPACITY = kct_pkg::CAPACITY_DEF,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  kct_pkg::entry_t wr_data,
	input  logic [AW-1:0]  rd_addr,
	output kct_pkg::entry_t rd_data
);
	import kct_pkg::*;

	entry_t mem_q [CAPACITY];
	entry_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data in the cycle after the address
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/kct_seq.sv -----
// Sequencer: scans entries through the shared key comparator, appends or
// compacts through the single storage write port, and holds the result register.
module kct_seq #(
	parameter int CAPACITY = kct_pkg::CAPACITY_DEF,
	parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	kct_req_if.sink         req,
	kct_rsp_if.source       rsp,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output kct_pkg::entry_t wr_data,
	output logic [AW-1:0]   rd_addr,
	input  kct_pkg::entry_t rd_data
);
	import kct_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t             state_q;
	logic [KIND_W-1:0]  kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [PAY_W-1:0]   pay_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      count_q;
	status_t            res_status_q;
	logic [PAY_W-1:0]   res_pay_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [PAY_W-1:0]   out_pay_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               accept;
	logic               hit;
	logic               last;
	logic               full;
	logic               out_free;
	logic [CW-1:0]      idx_inc;
	logic [CW:0]        idx_inc2;
	logic [CW+COUNT_W-1:0] count_ext;

	// Shared compare unit and index arithmetic
	assign accept   = req.valid && req.ready;
	assign idx_inc  = idx_q + CW'(1);
	assign idx_inc2 = {1'b0, idx_q} + (CW+1)'(2);
	assign hit      = (rd_data.key == key_q);
	assign last     = (idx_inc == count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign out_free = !out_valid_q || rsp.ready;
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.found_payload = out_pay_q;
	assign rsp.entry_count   = out_count_q;

	// Storage port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = '{key: key_q, payload: pay_q};
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				// empty table: add goes straight to slot 0
				if (accept && op_t'(req.kind) == OP_ADD && count_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = '{key: req.key, payload: req.entry_payload};
				end
			end
			S_SCAN: begin
				rd_addr = idx_inc[AW-1:0];
				if (!hit && last && op_t'(kind_q) == OP_ADD && !full) begin
					wr_en = 1'b1;
				end
			end
			S_SHIFT: begin
				rd_addr = idx_inc2[AW-1:0];
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_data;
			end
			default: ;
		endcase
	end

	// Sequencer state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= '0;
			key_q        <= '0;
			pay_q        <= '0;
			res_status_q <= ST_OK;
			res_pay_q    <= '0;
			out_status_q <= ST_OK;
			out_pay_q    <= '0;
			out_count_q  <= '0;
		end else begin
			// result register: load from the response state, clear when taken
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q    <= req.kind;
						key_q     <= req.key;
						pay_q     <= req.entry_payload;
						idx_q     <= '0;
						res_pay_q <= '0;
						case (op_t'(req.kind))
							OP_ADD, OP_FIND, OP_REMOVE: begin
								if (count_q != '0) begin
									res_status_q <= ST_OK;
									state_q      <= S_SCAN;
								end else if (op_t'(req.kind) == OP_ADD) begin
									res_status_q <= ST_OK;
									count_q      <= count_q + CW'(1);
									state_q      <= S_RESP;
								end else begin
									res_status_q <= ST_MISSING;
									state_q      <= S_RESP;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						case (op_t'(kind_q))
							OP_ADD: begin
								res_status_q <= ST_DUP;
								state_q      <= S_RESP;
							end
							OP_FIND: begin
								res_pay_q <= rd_data.payload;
								state_q   <= S_RESP;
							end
							OP_REMOVE: begin
								// matched the tail: nothing to close up
								if (last) begin
									count_q <= count_q - CW'(1);
									state_q <= S_RESP;
								end else begin
									state_q <= S_SHIFT;
								end
							end
							default: state_q <= S_RESP;
						endcase
					end else if (last) begin
						state_q <= S_RESP;
						if (op_t'(kind_q) == OP_ADD) begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end else begin
							res_status_q <= ST_MISSING;
						end
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_SHIFT: begin
					// entry idx+1 moves down into idx
					if (idx_inc2 == {1'b0, count_q}) begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_pay_q    <= res_pay_q;
						out_count_q  <= count_ext[COUNT_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Count never exceeds the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (CW+1)'(CAPACITY))
		else $error("live count above capacity");

	// Count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			(count_q == $past(count_q) + CW'(1) || count_q + CW'(1) == $past(count_q)))
		else $error("live count jumped");

	// A new result is loaded only from the response state
	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result loaded outside response state");

	// Storage is written only while a request is being worked or taken
	a_wr_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SCAN || state_q == S_SHIFT || accept))
		else $error("storage write outside a request");

	// Found payload is zero unless a find succeeded
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_OK) |-> (out_pay_q == '0))
		else $error("payload on a failed request");

endmodule

// ----- hw/rtl/keyed_compacting_table.sv -----
// Sequence: a taken request scans entries in order (up to the live count, stopping at a
//   match), on a remove then moves each later entry down, then loads the result register.
// Flow: one request in flight; the scan and the moves share the single storage read port,
//   and a held result stalls the response state until it is taken.
// Reset (arst_n, asynchronous, active low) clears the live count and control; entry
//   storage is not cleared, and only live entries are ever used.
module keyed_compacting_table #(
	parameter int CAPACITY = kct_pkg::CAPACITY_DEF
) (
	input logic       clk,
	input logic       arst_n,
	kct_req_if.sink   req,
	kct_rsp_if.source rsp
);
	import kct_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	entry_t        wr_data;
	entry_t        rd_data;

	// Request sequencer with the key comparator
	kct_seq #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Entry memory
	kct_store #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
